>>> hw/rtl/bpet_pkg.sv
// Shared types, constants and time-compare helper for the button press event tracker.
// No dependencies; every other file of the block uses this package by scoped names.
`timescale 1ns / 1ps

package bpet_pkg;

  // Lane count of the design; only the first eight lanes have pins, modes and output bits.
  localparam int BUTTONS = 8;
  localparam int LANES   = (BUTTONS < 8) ? BUTTONS : 8;

  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int CNT_W    = 4;
  localparam int MASK_W   = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GUARD    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(5);

  // Per-button mode codes; the code for single press and the unused code act alike
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_LONG   = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PRESS = 2'd1,
    ST_LONG  = 2'd2
  } bpet_state_t;

  typedef struct packed {
    logic [MS_W-1:0]   guard_ms;
    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   long_ms;
    logic [MS_W-1:0]   rep_ms;
    logic [CNT_W-1:0]  btn_count;
    logic [2*MASK_W-1:0] modes;
  } bpet_cfg_t;

  typedef struct packed {
    logic press_ev;
    logic long_ev;
    logic rel_ev;
    logic held;
  } bpet_lane_ev_t;

  typedef struct packed {
    logic [MASK_W-1:0] press_events;
    logic [MASK_W-1:0] long_press_events;
    logic [MASK_W-1:0] release_events;
    logic [MASK_W-1:0] still_held;
  } bpet_result_t;

  // Strict unsigned now > base + delta, the sum wrapping at 2^32
  function automatic logic later_than(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] base,
                                      input logic [MS_W-1:0]   delta);
    logic [TIME_W-1:0] sum;
    sum = base + TIME_W'(delta);
    return now > sum;
  endfunction

endpackage

>>> hw/rtl/bpet_in_if.sv
// Poll input channel: valid/ready handshake with time stamp and pin levels.
// Depends on bpet_pkg for field widths.
`timescale 1ns / 1ps

interface bpet_in_if;
  logic                           valid;
  logic                           ready;
  logic [bpet_pkg::TIME_W-1:0]    now_ms;
  logic [bpet_pkg::MASK_W-1:0]    pin_active;

  modport source (output valid, output now_ms, output pin_active, input ready);
  modport sink   (input valid, input now_ms, input pin_active, output ready);
endinterface

>>> hw/rtl/bpet_out_if.sv
// Result channel: valid/ready handshake with the four event masks.
// Depends on bpet_pkg for field widths.
`timescale 1ns / 1ps

interface bpet_out_if;
  logic                           valid;
  logic                           ready;
  logic [bpet_pkg::MASK_W-1:0]    press_events;
  logic [bpet_pkg::MASK_W-1:0]    long_press_events;
  logic [bpet_pkg::MASK_W-1:0]    release_events;
  logic [bpet_pkg::MASK_W-1:0]    still_held;

  modport source (output valid, output press_events, output long_press_events,
                  output release_events, output still_held, input ready);
  modport sink   (input valid, input press_events, input long_press_events,
                  input release_events, input still_held, output ready);
endinterface

>>> hw/rtl/bpet_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on bpet_pkg for field widths.
`timescale 1ns / 1ps

interface bpet_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpet_pkg::CFG_IDX_W-1:0]  index;
  logic [bpet_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bpet_cfg_regs.sv
// Configuration register file of the button press event tracker.
// Depends on bpet_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module bpet_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [bpet_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bpet_pkg::CFG_DAT_W-1:0]  wr_data,
  output bpet_pkg::bpet_cfg_t             cfg
);

  bpet_pkg::bpet_cfg_t cfg_r;
  bpet_pkg::bpet_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        bpet_pkg::REG_GUARD:    cfg_nxt.guard_ms    = wr_data;
        bpet_pkg::REG_DEBOUNCE: cfg_nxt.debounce_ms = wr_data;
        bpet_pkg::REG_LONG:     cfg_nxt.long_ms     = wr_data;
        bpet_pkg::REG_REPEAT:   cfg_nxt.rep_ms      = wr_data;
        bpet_pkg::REG_COUNT:    cfg_nxt.btn_count   = wr_data[bpet_pkg::CNT_W-1:0];
        bpet_pkg::REG_MODE:     cfg_nxt.modes       = wr_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.guard_ms    <= bpet_pkg::MS_W'(100);
      cfg_r.debounce_ms <= bpet_pkg::MS_W'(50);
      cfg_r.long_ms     <= bpet_pkg::MS_W'(1000);
      cfg_r.rep_ms      <= bpet_pkg::MS_W'(200);
      cfg_r.btn_count   <= '0;
      cfg_r.modes       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/bpet_lane.sv
// One button lane: debounce, press, long-press and auto-repeat tracking.
// Depends on bpet_pkg for the state enum, mode codes and time compare.
`timescale 1ns / 1ps

module bpet_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           poll,      // a poll transfers this cycle
  input  logic                           enabled,   // lane is registered
  input  logic [bpet_pkg::TIME_W-1:0]    now_ms,
  input  logic                           active,
  input  logic [1:0]                     mode,
  input  bpet_pkg::bpet_cfg_t            cfg,
  output bpet_pkg::bpet_lane_ev_t        ev
);

  logic [bpet_pkg::TIME_W-1:0] track_r, track_nxt;
  logic [bpet_pkg::TIME_W-1:0] last_r, last_nxt;
  bpet_pkg::bpet_state_t       state_r, state_nxt;

  logic tracking;
  logic guard_done, debounce_done, long_done, rep_done;

  assign tracking      = (track_r != '0);
  assign guard_done    = bpet_pkg::later_than(now_ms, last_r, cfg.guard_ms);
  assign debounce_done = bpet_pkg::later_than(now_ms, track_r, cfg.debounce_ms);
  assign long_done     = bpet_pkg::later_than(now_ms, track_r, cfg.long_ms);
  assign rep_done      = bpet_pkg::later_than(now_ms, last_r, cfg.rep_ms);

  // Next state
  always_comb begin
    track_nxt = track_r;
    last_nxt  = last_r;
    state_nxt = state_r;
    if (!enabled) begin
      track_nxt = '0;
      last_nxt  = '0;
      state_nxt = bpet_pkg::ST_IDLE;
    end else if (!tracking) begin
      if (active && guard_done) track_nxt = now_ms;
    end else if (active) begin
      unique case (state_r)
        bpet_pkg::ST_IDLE: begin
          if (debounce_done) begin
            state_nxt = bpet_pkg::ST_PRESS;
            last_nxt  = now_ms;
          end
        end
        bpet_pkg::ST_PRESS: begin
          if (mode == bpet_pkg::MODE_LONG && long_done) begin
            state_nxt = bpet_pkg::ST_LONG;
            last_nxt  = now_ms;
          end else if (mode == bpet_pkg::MODE_REPEAT && rep_done) begin
            last_nxt = now_ms;
          end
        end
        default: ;
      endcase
    end else if (state_r == bpet_pkg::ST_IDLE) begin
      // drop a glitch that never became a press
      if (debounce_done) begin
        track_nxt = '0;
        last_nxt  = now_ms;
      end
    end else begin
      state_nxt = bpet_pkg::ST_IDLE;
      track_nxt = '0;
      last_nxt  = now_ms;
    end
  end

  // Outputs
  always_comb begin
    ev = '0;
    if (enabled && tracking) begin
      if (active) begin
        ev.press_ev = (state_r == bpet_pkg::ST_IDLE && debounce_done) ||
                      (state_r == bpet_pkg::ST_PRESS && mode == bpet_pkg::MODE_REPEAT &&
                       rep_done);
        ev.long_ev  = state_r == bpet_pkg::ST_PRESS && mode == bpet_pkg::MODE_LONG &&
                      long_done;
      end else begin
        ev.rel_ev = (state_r != bpet_pkg::ST_IDLE);
      end
    end
    ev.held = enabled && active && (state_nxt != bpet_pkg::ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
      last_r  <= '0;
      state_r <= bpet_pkg::ST_IDLE;
    end else if (poll) begin
      track_r <= track_nxt;
      last_r  <= last_nxt;
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/bpet_merge.sv
// Merge stage: packs the lane events into masks and buffers two results.
// Depends on bpet_pkg for the lane event and result structs.
`timescale 1ns / 1ps

module bpet_merge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  bpet_pkg::bpet_lane_ev_t   lane_ev [bpet_pkg::LANES],
  output logic                      can_push,
  output logic                      res_valid,
  input  logic                      res_ready,
  output bpet_pkg::bpet_result_t    res
);

  bpet_pkg::bpet_result_t packed_res;
  bpet_pkg::bpet_result_t buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  always_comb begin
    packed_res = '0;
    for (int i = 0; i < bpet_pkg::LANES; i++) begin
      packed_res.press_events[i]      = lane_ev[i].press_ev;
      packed_res.long_press_events[i] = lane_ev[i].long_ev;
      packed_res.release_events[i]    = lane_ev[i].rel_ev;
      packed_res.still_held[i]        = lane_ev[i].held;
    end
  end

  assign can_push  = (cnt_r != 2'd2);
  assign res_valid = (cnt_r != 2'd0);
  assign pop       = res_valid && res_ready;
  assign res       = buf_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= packed_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/button_press_event_tracker_unit.sv
// A poll's result goes into the result buffer and is shown once earlier results are taken.
// One poll per cycle while the buffer has room; every lane updates in the transfer cycle.
// A two-entry result buffer lets polls keep flowing while one result waits to be taken.
// Reset (rst_n low, synchronous): lanes idle with zero times, registers at their defaults,
// result buffer empty. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module button_press_event_tracker_unit (
  input  logic          clk,
  input  logic          rst_n,
  bpet_in_if.sink       in_ch,
  bpet_out_if.source    out_ch,
  bpet_cfg_if.sink      cfg_ch
);

  bpet_pkg::bpet_cfg_t      cfg;
  bpet_pkg::bpet_lane_ev_t  lane_ev [bpet_pkg::LANES];
  bpet_pkg::bpet_result_t   res;
  logic                     poll;
  logic                     can_push;

  // Configuration port never stalls.
  assign cfg_ch.ready = 1'b1;

  bpet_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // A poll transfers whenever the result buffer has a free slot.
  assign in_ch.ready = can_push;
  assign poll        = in_ch.valid && can_push;

  // One lane per button. A lane is registered while its index is below the button
  // count; with at most eight lanes this is the same as comparing with the limited count.
  for (genvar i = 0; i < bpet_pkg::LANES; i++) begin : g_lane
    bpet_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .poll    (poll),
      .enabled (cfg.btn_count > bpet_pkg::CNT_W'(i)),
      .now_ms  (in_ch.now_ms),
      .active  (in_ch.pin_active[i]),
      .mode    (cfg.modes[2*i +: 2]),
      .cfg     (cfg),
      .ev      (lane_ev[i])
    );
  end

  // Pack lane events into masks and hold them until the sink takes them.
  bpet_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (poll),
    .lane_ev   (lane_ev),
    .can_push  (can_push),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.press_events      = res.press_events;
  assign out_ch.long_press_events = res.long_press_events;
  assign out_ch.release_events    = res.release_events;
  assign out_ch.still_held        = res.still_held;

endmodule

>>> hw/rtl/bpet_checker.sv
// Port-level checker for the button press event tracker, bound to the top level.
// Depends on bpet_pkg for field widths.
`timescale 1ns / 1ps

module bpet_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bpet_pkg::MASK_W-1:0]  press_events,
  input logic [bpet_pkg::MASK_W-1:0]  long_press_events,
  input logic [bpet_pkg::MASK_W-1:0]  release_events,
  input logic [bpet_pkg::MASK_W-1:0]  still_held
);

  // A pending result holds until it transfers.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(press_events) && $stable(long_press_events) &&
                                $stable(release_events) && $stable(still_held))
    else $error("stalled result changed");

  // A button cannot be released and pressed, long-pressed or held in one poll.
  a_event_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((release_events & (press_events | long_press_events | still_held)) == '0)
                  && ((press_events & long_press_events) == '0))
    else $error("conflicting events for one button");

  // Polls stall only while results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind button_press_event_tracker_unit bpet_checker u_bpet_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .press_events      (out_ch.press_events),
  .long_press_events (out_ch.long_press_events),
  .release_events    (out_ch.release_events),
  .still_held        (out_ch.still_held)
);

>>> dv/tb_button_press_event_tracker_unit.sv
// Self-checking testbench for button_press_event_tracker_unit: random and directed polls,
// a lane-by-lane event predictor and a checker on the result channel.
// Depends on bpet_pkg and the bpet_in_if, bpet_out_if and bpet_cfg_if interfaces.
`timescale 1ns / 1ps

module tb_button_press_event_tracker_unit;

  // End the run when this many cycles pass without any transfer on any channel
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;
  // Indexes past the register list; writes to them must change nothing
  localparam logic [bpet_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = bpet_pkg::CFG_IDX_W'(6);
  localparam logic [bpet_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  // Receiver stall styles
  typedef enum logic [1:0] {
    RX_FREE    = 2'd0,
    RX_MOSTLY  = 2'd1,
    RX_SPARSE  = 2'd2,
    RX_PATTERN = 2'd3
  } rx_style_t;

  logic clk;
  logic rst_n;

  bpet_in_if  in_if();
  bpet_out_if out_if();
  bpet_cfg_if cfg_if();

  button_press_event_tracker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Lane state of the predictor
  logic [bpet_pkg::TIME_W-1:0] trk_start [bpet_pkg::LANES];
  logic [bpet_pkg::TIME_W-1:0] last_evt  [bpet_pkg::LANES];
  bpet_pkg::bpet_state_t       lane_st   [bpet_pkg::LANES];

  // Register copies of the predictor
  logic [bpet_pkg::MS_W-1:0]     cfg_guard_ms;
  logic [bpet_pkg::MS_W-1:0]     cfg_debounce_ms;
  logic [bpet_pkg::MS_W-1:0]     cfg_long_ms;
  logic [bpet_pkg::MS_W-1:0]     cfg_rep_ms;
  logic [bpet_pkg::CNT_W-1:0]    cfg_count;
  logic [2*bpet_pkg::MASK_W-1:0] cfg_modes;

  // Event masks still owed by the block, oldest first
  bpet_pkg::bpet_result_t event_mask_q [$];

  int err_count;
  int idle_cycles;
  int burst_left;
  int hold_len;
  int step_scale;
  logic [bpet_pkg::TIME_W-1:0] poll_time;
  logic [bpet_pkg::MASK_W-1:0] pin_level;

  // True when now lies strictly past base + delta; the sum wraps at 32 bits
  function automatic logic time_passed(input logic [bpet_pkg::TIME_W-1:0] now,
                                       input logic [bpet_pkg::TIME_W-1:0] base,
                                       input logic [bpet_pkg::MS_W-1:0]   delta);
    time_passed = now > (base + bpet_pkg::TIME_W'(delta));
  endfunction

  // Advance every lane by one poll and return the event masks it produces
  function automatic bpet_pkg::bpet_result_t predict_lane_events(
      input logic [bpet_pkg::TIME_W-1:0] now,
      input logic [bpet_pkg::MASK_W-1:0] pins);
    bpet_pkg::bpet_result_t r;
    int n_reg;
    logic [1:0] md;
    r = '0;
    n_reg = (cfg_count > bpet_pkg::LANES) ? bpet_pkg::LANES : cfg_count;
    for (int i = 0; i < bpet_pkg::LANES; i++) begin
      md = cfg_modes[2*i +: 2];
      if (i >= n_reg) begin
        // unregistered lanes fall back to reset every poll
        trk_start[i] = '0;
        last_evt[i]  = '0;
        lane_st[i]   = bpet_pkg::ST_IDLE;
      end else begin
        if (trk_start[i] == '0) begin
          // a start at time zero stores zero, so the lane stays untracked
          if (pins[i] && time_passed(now, last_evt[i], cfg_guard_ms))
            trk_start[i] = now;
        end else if (pins[i]) begin
          case (lane_st[i])
            bpet_pkg::ST_IDLE: begin
              if (time_passed(now, trk_start[i], cfg_debounce_ms)) begin
                lane_st[i] = bpet_pkg::ST_PRESS;
                r.press_events[i] = 1'b1;
                last_evt[i] = now;
              end
            end
            bpet_pkg::ST_PRESS: begin
              // mode 3 falls through like single press
              if (md == bpet_pkg::MODE_LONG) begin
                if (time_passed(now, trk_start[i], cfg_long_ms)) begin
                  lane_st[i] = bpet_pkg::ST_LONG;
                  r.long_press_events[i] = 1'b1;
                  last_evt[i] = now;
                end
              end else if (md == bpet_pkg::MODE_REPEAT) begin
                if (time_passed(now, last_evt[i], cfg_rep_ms)) begin
                  r.press_events[i] = 1'b1;
                  last_evt[i] = now;
                end
              end
            end
            default: ;
          endcase
        end else if (lane_st[i] == bpet_pkg::ST_IDLE) begin
          // glitch that never became a press: drop it and start the guard time
          if (time_passed(now, trk_start[i], cfg_debounce_ms)) begin
            trk_start[i] = '0;
            last_evt[i]  = now;
          end
        end else begin
          r.release_events[i] = 1'b1;
          lane_st[i]   = bpet_pkg::ST_IDLE;
          trk_start[i] = '0;
          last_evt[i]  = now;
        end
        r.still_held[i] = (lane_st[i] != bpet_pkg::ST_IDLE) && pins[i];
      end
    end
    return r;
  endfunction

  function automatic logic [bpet_pkg::MS_W-1:0] random_ms();
    case ($urandom_range(0, 3))
      0:       return bpet_pkg::MS_W'($urandom_range(0, 8));
      1:       return bpet_pkg::MS_W'($urandom_range(0, 100));
      2:       return bpet_pkg::MS_W'($urandom_range(0, 1000));
      default: return bpet_pkg::MS_W'($urandom());
    endcase
  endfunction

  task automatic log_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_mask(input string field, input logic [bpet_pkg::MASK_W-1:0] want,
                            input logic [bpet_pkg::MASK_W-1:0] got);
    if (got !== want)
      log_error($sformatf("%s expected %02h actual %02h", field, want, got));
  endtask

  // Offer one poll, hold it until its transfer, then record the masks it owes.
  // The sender runs in bursts; an exhausted burst drops valid for a random gap.
  task automatic send_poll(input logic [bpet_pkg::TIME_W-1:0] t,
                           input logic [bpet_pkg::MASK_W-1:0] pins);
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 16);
    end
    in_if.valid      <= 1'b1;
    in_if.now_ms     <= t;
    in_if.pin_active <= pins;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    event_mask_q.push_back(predict_lane_events(t, pins));
    burst_left--;
  endtask

  // Stop offering, wait until every owed result has arrived, then let the result buffer settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (event_mask_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Raise the write and hold it until its transfer; the caller drops valid
  task automatic write_reg(input logic [bpet_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpet_pkg::CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      bpet_pkg::REG_GUARD:    cfg_guard_ms    = val;
      bpet_pkg::REG_DEBOUNCE: cfg_debounce_ms = val;
      bpet_pkg::REG_LONG:     cfg_long_ms     = val;
      bpet_pkg::REG_REPEAT:   cfg_rep_ms      = val;
      bpet_pkg::REG_COUNT:    cfg_count       = val[bpet_pkg::CNT_W-1:0];
      bpet_pkg::REG_MODE:     cfg_modes       = val;
      default: ;
    endcase
  endtask

  // Drain the block, rewrite all registers, and size time steps to the new times
  task automatic apply_settings(input logic [bpet_pkg::MS_W-1:0] guard,
                                input logic [bpet_pkg::MS_W-1:0] deb,
                                input logic [bpet_pkg::MS_W-1:0] lng,
                                input logic [bpet_pkg::MS_W-1:0] rep,
                                input logic [bpet_pkg::CNT_W-1:0] cnt,
                                input logic [2*bpet_pkg::MASK_W-1:0] modes);
    logic [bpet_pkg::CFG_DAT_W-1:0] cnt_word;
    cnt_word = bpet_pkg::CFG_DAT_W'($urandom());
    cnt_word[bpet_pkg::CNT_W-1:0] = cnt;
    wait_idle();
    write_reg(bpet_pkg::REG_GUARD, guard);
    write_reg(bpet_pkg::REG_DEBOUNCE, deb);
    write_reg(bpet_pkg::REG_LONG, lng);
    write_reg(bpet_pkg::REG_REPEAT, rep);
    write_reg(bpet_pkg::REG_COUNT, cnt_word);
    write_reg(bpet_pkg::REG_MODE, modes);
    cfg_if.valid <= 1'b0;
    step_scale = 1 + (int'(guard) + int'(deb) + int'(lng) + int'(rep)) / 8;
  endtask

  // Random polls: time mostly creeps forward on the scale of the configured
  // times, with repeats and full-range jumps; buttons toggle now and then so
  // presses are held long enough to debounce, with some pure noise mixed in
  task automatic run_random(input int n);
    int r;
    logic [bpet_pkg::MASK_W-1:0] flips;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 5)
        ;
      else if (r < 10)
        poll_time = $urandom();
      else if (r < 80)
        poll_time += $urandom_range(0, step_scale);
      else
        poll_time += $urandom_range(0, 4 * step_scale);
      flips = '0;
      for (int b = 0; b < bpet_pkg::MASK_W; b++)
        if ($urandom_range(0, 5) == 0) flips[b] = 1'b1;
      if ($urandom_range(0, 11) == 0)
        pin_level = bpet_pkg::MASK_W'($urandom());
      else
        pin_level ^= flips;
      send_poll(poll_time, pin_level);
    end
  endtask

  // Out of reset no lane is registered: every mask must read zero
  task automatic test_reset_defaults();
    send_poll(32'd0, 8'hFF);
    send_poll(32'd5000, 8'hFF);
    send_poll(32'hFFFF_FFFF, 8'hFF);
    send_poll(32'd1, 8'h00);
  endtask

  // Walk each mode through press, long press, repeat, glitch, release and a
  // press that spans the 32-bit time wrap. Lanes 0..7 use modes
  // single, long, repeat, unused code, long, repeat, single, unused code.
  task automatic test_press_modes();
    apply_settings(16'd10, 16'd20, 16'd100, 16'd30, bpet_pkg::CNT_W'(8), 16'hC9E4);
    send_poll(32'd0, 8'hFF);            // start at time zero stays untracked
    send_poll(32'd1000, 8'h0F);         // lanes 0-3 start tracking
    send_poll(32'd1015, 8'h0F);
    send_poll(32'd1021, 8'h0F);         // press on lanes 0-3
    send_poll(32'd1040, 8'h0F);
    send_poll(32'd1052, 8'h0F);         // repeat on lane 2
    send_poll(32'd1101, 8'h0F);         // long press on lane 1, repeat again
    send_poll(32'd1150, 8'h1F);         // lane 4 begins
    send_poll(32'd1160, 8'h0F);
    send_poll(32'd1175, 8'h0F);         // lane 4 glitch dropped
    send_poll(32'd1180, 8'h1F);         // still inside the guard time
    send_poll(32'd1190, 8'h1F);
    send_poll(32'd1200, 8'h00);         // release on lanes 0-3
    send_poll(32'd1205, 8'hF0);
    send_poll(32'd1300, 8'hF0);
    send_poll(32'd1400, 8'hF0);
    send_poll(32'd1500, 8'h00);
    send_poll(32'hFFFF_FFF0, 8'h01);    // tracking starts just before the wrap
    send_poll(32'hFFFF_FFFA, 8'h01);
    send_poll(32'h0000_0010, 8'h01);    // lane 0 still held after the wrap
    send_poll(32'h0000_0020, 8'h00);
    poll_time = 32'h0000_0020;
    pin_level = '0;
  endtask

  // Writes past the register list are ignored; the count register only keeps
  // its low bits, and three lanes leave the rest unregistered
  task automatic test_register_corners();
    wait_idle();
    write_reg(REG_UNUSED_LO, '1);
    write_reg(REG_UNUSED_HI, 16'h5A5A);
    write_reg(bpet_pkg::REG_COUNT, 16'hFFF3);
    cfg_if.valid <= 1'b0;
    step_scale = 20;
    run_random(25);
  endtask

  // Zero and full-scale times, counts past the lane limit and uniform or random mode words
  task automatic test_config_extremes();
    apply_settings('0, '0, '0, '0, bpet_pkg::CNT_W'(8), 16'($urandom()));
    run_random(40);
    apply_settings('1, '1, '1, '1, bpet_pkg::CNT_W'(15), 16'hFFFF);
    run_random(40);
    apply_settings('0, '1, '0, 16'd1, bpet_pkg::CNT_W'(9), 16'hAAAA);
    run_random(40);
    apply_settings('1, '0, '1, '0, bpet_pkg::CNT_W'(1), 16'h5555);
    run_random(30);
  endtask

  task automatic test_random_settings();
    logic [bpet_pkg::CNT_W-1:0] cnt;
    repeat (6) begin
      cnt = ($urandom_range(0, 2) != 0) ? bpet_pkg::CNT_W'(8)
                                        : bpet_pkg::CNT_W'($urandom_range(0, 15));
      apply_settings(random_ms(), random_ms(), random_ms(), random_ms(), cnt,
                     16'($urandom()));
      run_random(55);
    end
  endtask

  // Hold the result side off for a long stretch while polls keep coming, so
  // the result buffer fills and the input stalls; then pause until all is in
  task automatic test_backpressure();
    apply_settings(16'd5, 16'd15, 16'd60, 16'd20, bpet_pkg::CNT_W'(8), 16'($urandom()));
    hold_len = 300;
    run_random(60);
    wait_idle();
    run_random(20);
  endtask

  // Receiver: switch between stall styles at random, and honor a requested
  // hold-off by counting it down here
  initial begin
    int hold_cnt;
    int style_left;
    int k;
    rx_style_t style;
    logic [7:0] pat;
    hold_cnt   = 0;
    style_left = 0;
    k          = 0;
    style      = RX_FREE;
    pat        = '1;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (style_left == 0) begin
        style      = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 80);
        pat        = 8'($urandom()) | 8'h01;
      end
      style_left--;
      k++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        case (style)
          RX_FREE:   out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 2) == 0);
          default:   out_if.ready <= pat[k % 8];
        endcase
      end
    end
  end

  // Checker: compare each result transfer with the oldest owed masks
  always @(posedge clk) begin : result_check
    bpet_pkg::bpet_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (event_mask_q.size() == 0) begin
        log_error($sformatf("result %02h %02h %02h %02h with no poll outstanding",
                            out_if.press_events, out_if.long_press_events,
                            out_if.release_events, out_if.still_held));
      end else begin
        want = event_mask_q.pop_front();
        check_mask("press_events", want.press_events, out_if.press_events);
        check_mask("long_press_events", want.long_press_events, out_if.long_press_events);
        check_mask("release_events", want.release_events, out_if.release_events);
        check_mask("still_held", want.still_held, out_if.still_held);
      end
    end
  end

  // Watchdog: count cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.now_ms      = '0;
    in_if.pin_active  = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    for (int i = 0; i < bpet_pkg::LANES; i++) begin
      trk_start[i] = '0;
      last_evt[i]  = '0;
      lane_st[i]   = bpet_pkg::ST_IDLE;
    end
    cfg_guard_ms    = 16'd100;
    cfg_debounce_ms = 16'd50;
    cfg_long_ms     = 16'd1000;
    cfg_rep_ms      = 16'd200;
    cfg_count       = '0;
    cfg_modes       = '0;
    err_count   = 0;
    idle_cycles = 0;
    burst_left  = 0;
    hold_len    = 0;
    step_scale  = 20;
    poll_time   = '0;
    pin_level   = '0;

    // hold reset, then release it for good
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_press_modes();
    test_register_corners();
    test_config_extremes();
    test_random_settings();
    test_backpressure();
    wait_idle();

    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bpet_pkg.sv
hw/rtl/bpet_in_if.sv
hw/rtl/bpet_out_if.sv
hw/rtl/bpet_cfg_if.sv
hw/rtl/bpet_cfg_regs.sv
hw/rtl/bpet_lane.sv
hw/rtl/bpet_merge.sv
hw/rtl/button_press_event_tracker_unit.sv
hw/rtl/bpet_checker.sv
dv/tb_button_press_event_tracker_unit.sv
